FILE: sv/ttr_pkg.sv
// ----------------------------------------------------------------------------
// ttr_pkg
// Shared widths, register indexes and stage context types for the texture
// target resolution unit.
// ----------------------------------------------------------------------------
package ttr_pkg;

  localparam int SIDE_W  = 15;
  localparam int BLK_W   = 5;
  localparam int STEPS   = SIDE_W;
  localparam int CFG_W   = 15;
  localparam int IDX_W   = 2;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [BLK_W-1:0]  blk_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DOWNSCALE = 2'd0,
    REG_MIN_SIDE  = 2'd1,
    REG_MAX_SIDE  = 2'd2,
    REG_VOLUME    = 2'd3
  } reg_idx_t;

  // Context carried beside the aspect division
  typedef struct packed {
    side_t ow;
    side_t oh;
    side_t tw0;
    side_t th0;
    logic  wgt;
    logic  lt;
    logic  align;
    blk_t  bw;
    blk_t  bh;
  } ctx1_t;

  // Context beside the scale division (orig_height / target_height)
  typedef struct packed {
    side_t ow;
    side_t tw1;
    side_t th1;
    logic  align;
    blk_t  bw;
    blk_t  bh;
    logic  hzero;
  } ctx2_t;

  // Context beside the volume width division
  typedef struct packed {
    side_t tw1;
    side_t th1;
    logic  align;
    blk_t  bw;
    blk_t  bh;
    logic  hzero;
    logic  szero;
  } ctx3_t;

  // Context beside the width block division
  typedef struct packed {
    side_t th2;
    side_t tw2;
    blk_t  bwd;
    blk_t  bhd;
    logic  align;
    logic  fault;
  } ctx4_t;

  // Context beside the height block division
  typedef struct packed {
    side_t th2;
    side_t tw2;
    side_t remw;
    blk_t  bwd;
    blk_t  bhd;
    logic  align;
    logic  fault;
  } ctx5_t;

endpackage

FILE: sv/ttr_if.sv
// ----------------------------------------------------------------------------
// ttr_in_if / ttr_out_if
// Valid/ready channels for resolution queries and results.
// ----------------------------------------------------------------------------
interface ttr_in_if;
  logic                valid;
  logic                ready;
  ttr_pkg::side_t      orig_width;
  ttr_pkg::side_t      orig_height;
  logic                align_needed;
  ttr_pkg::blk_t       block_w;
  ttr_pkg::blk_t       block_h;

  modport source (output valid, orig_width, orig_height, align_needed, block_w, block_h,
                  input ready);
  modport sink   (input valid, orig_width, orig_height, align_needed, block_w, block_h,
                  output ready);
endinterface

interface ttr_out_if;
  logic                valid;
  logic                ready;
  ttr_pkg::side_t      target_width;
  ttr_pkg::side_t      target_height;
  logic                align_adjusted;
  logic                divide_fault;

  modport source (output valid, target_width, target_height, align_adjusted, divide_fault,
                  input ready);
  modport sink   (input valid, target_width, target_height, align_adjusted, divide_fault,
                  output ready);
endinterface

FILE: sv/ttr_div_cell.sv
// ----------------------------------------------------------------------------
// ttr_div_cell
// One restoring division step: develops one quotient bit and hands the
// partial remainder, dividend bits, divisor and context to the next cell.
// ----------------------------------------------------------------------------
module ttr_div_cell #(
  parameter int CW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ttr_pkg::side_t        in_rem,
  input  ttr_pkg::side_t        in_nlo,
  input  ttr_pkg::side_t        in_quo,
  input  ttr_pkg::side_t        in_dvs,
  input  logic [CW-1:0]         in_ctx,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ttr_pkg::side_t        out_rem,
  output ttr_pkg::side_t        out_nlo,
  output ttr_pkg::side_t        out_quo,
  output ttr_pkg::side_t        out_dvs,
  output logic [CW-1:0]         out_ctx
);

  logic                   valid_r;
  ttr_pkg::side_t         rem_r, nlo_r, quo_r, dvs_r;
  logic [CW-1:0]          ctx_r;
  logic [ttr_pkg::SIDE_W:0] trial;
  logic [ttr_pkg::SIDE_W:0] diff;
  logic                   ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {in_rem, in_nlo[ttr_pkg::SIDE_W-1]};
  assign diff  = trial - {1'b0, in_dvs};
  assign ge    = (trial >= {1'b0, in_dvs});

  // Take a beat whenever this cell is empty or its contents move on
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r <= ge ? diff[ttr_pkg::SIDE_W-1:0] : trial[ttr_pkg::SIDE_W-1:0];
      nlo_r <= {in_nlo[ttr_pkg::SIDE_W-2:0], 1'b0};
      quo_r <= {in_quo[ttr_pkg::SIDE_W-2:0], ge};
      dvs_r <= in_dvs;
      ctx_r <= in_ctx;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_nlo   = nlo_r;
  assign out_quo   = quo_r;
  assign out_dvs   = dvs_r;
  assign out_ctx   = ctx_r;

endmodule

FILE: sv/ttr_div_chain.sv
// ----------------------------------------------------------------------------
// ttr_div_chain
// Row of division cells giving a 15-bit quotient and remainder, one quotient
// bit per cell, one new division entering every cycle while not stalled.
// ----------------------------------------------------------------------------
module ttr_div_chain #(
  parameter int CW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ttr_pkg::side_t        in_rem,
  input  ttr_pkg::side_t        in_nlo,
  input  ttr_pkg::side_t        in_dvs,
  input  logic [CW-1:0]         in_ctx,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ttr_pkg::side_t        out_quo,
  output ttr_pkg::side_t        out_rem,
  output logic [CW-1:0]         out_ctx
);

  localparam int N = ttr_pkg::STEPS;

  logic           v   [0:N];
  logic           rdy [0:N];
  ttr_pkg::side_t rem [0:N];
  ttr_pkg::side_t nlo [0:N];
  ttr_pkg::side_t quo [0:N];
  ttr_pkg::side_t dvs [0:N];
  logic [CW-1:0]  ctx [0:N];

  assign v[0]   = in_valid;
  assign rem[0] = in_rem;
  assign nlo[0] = in_nlo;
  assign quo[0] = '0;
  assign dvs[0] = in_dvs;
  assign ctx[0] = in_ctx;
  assign in_ready = rdy[0];
  assign rdy[N] = out_ready;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ttr_div_cell #(.CW(CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[i]),
      .in_ready  (rdy[i]),
      .in_rem    (rem[i]),
      .in_nlo    (nlo[i]),
      .in_quo    (quo[i]),
      .in_dvs    (dvs[i]),
      .in_ctx    (ctx[i]),
      .out_valid (v[i+1]),
      .out_ready (rdy[i+1]),
      .out_rem   (rem[i+1]),
      .out_nlo   (nlo[i+1]),
      .out_quo   (quo[i+1]),
      .out_dvs   (dvs[i+1]),
      .out_ctx   (ctx[i+1])
    );
  end

  // Trailing dividend bits and divisor are spent at the end of the row
  logic unused_tail;
  assign unused_tail = ^{nlo[N], dvs[N]};

  assign out_valid = v[N] & (unused_tail | ~unused_tail);
  assign out_quo   = quo[N];
  assign out_rem   = rem[N];
  assign out_ctx   = ctx[N];

endmodule

FILE: sv/ttr_front.sv
// ----------------------------------------------------------------------------
// ttr_front
// Entry cell: downscale and clamp both sides, pick the aspect case and form
// the product that the aspect division consumes.
// ----------------------------------------------------------------------------
module ttr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [3:0]            steps,
  input  ttr_pkg::side_t        min_side,
  input  ttr_pkg::side_t        max_side,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ttr_pkg::side_t        ow,
  input  ttr_pkg::side_t        oh,
  input  logic                  align,
  input  ttr_pkg::blk_t         bw,
  input  ttr_pkg::blk_t         bh,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2*ttr_pkg::SIDE_W-1:0] out_prod,
  output ttr_pkg::side_t        out_dvs,
  output ttr_pkg::ctx1_t        out_ctx
);

  logic                          valid_r;
  logic [2*ttr_pkg::SIDE_W-1:0]  prod_r, prod_nxt;
  ttr_pkg::side_t                dvs_r, dvs_nxt;
  ttr_pkg::ctx1_t                ctx_r, ctx_nxt;
  ttr_pkg::side_t                sw, sh, tw0, th0, ma, mb;
  logic                          wgt, lt;

  // Shift down, then clamp with the lower bound taking priority
  always_comb begin
    sw  = ow >> steps;
    sh  = oh >> steps;
    tw0 = (sw < min_side) ? min_side : ((max_side < sw) ? max_side : sw);
    th0 = (sh < min_side) ? min_side : ((max_side < sh) ? max_side : sh);
    wgt = (ow > oh);
    lt  = (ow < oh);
    ma  = wgt ? tw0 : th0;
    mb  = wgt ? oh  : ow;
    prod_nxt = (wgt || lt) ? ma * mb : '0;
    dvs_nxt  = wgt ? ow : (lt ? oh : ttr_pkg::side_t'(1));
    ctx_nxt  = '{ow: ow, oh: oh, tw0: tw0, th0: th0, wgt: wgt, lt: lt,
                 align: align, bw: bw, bh: bh};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
      dvs_r  <= dvs_nxt;
      ctx_r  <= ctx_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;
  assign out_dvs   = dvs_r;
  assign out_ctx   = ctx_r;

endmodule

FILE: sv/texture_target_resolution_unit.sv
// ----------------------------------------------------------------------------
// texture_target_resolution_unit
// Computes the target size of a converted texture from its original size.
// ----------------------------------------------------------------------------
// Accepts one query per cycle while the output is not stalled and returns one
// result per query, in order, through one entry cell (downscale, clamp, aspect
// product), then five rows of 15 division cells each (aspect ratio, volume
// scale factor, volume width, width block remainder, height block remainder)
// and one output register. Every cell holds one beat, so a stalled output
// fills the rows before the input ready drops. The user must write the
// configuration registers only while idle; the block does not enforce this.
module texture_target_resolution_unit #(
  parameter int MAX_SIDE = 16384
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [ttr_pkg::IDX_W-1:0] cfg_idx,
  input  logic [ttr_pkg::CFG_W-1:0] cfg_wdata,
  ttr_in_if.sink                  in_ch,
  ttr_out_if.source               out_ch
);

  localparam logic [16:0] MAX_SIDE_V = 17'(MAX_SIDE);

  localparam int CW1 = $bits(ttr_pkg::ctx1_t);
  localparam int CW2 = $bits(ttr_pkg::ctx2_t);
  localparam int CW3 = $bits(ttr_pkg::ctx3_t);
  localparam int CW4 = $bits(ttr_pkg::ctx4_t);
  localparam int CW5 = $bits(ttr_pkg::ctx5_t);

  // Configuration registers
  logic [3:0]      steps_r;
  ttr_pkg::side_t  min_r, max_r;
  logic            vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      min_r   <= ttr_pkg::side_t'(1);
      max_r   <= MAX_SIDE_V[ttr_pkg::SIDE_W-1:0];
      vol_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (ttr_pkg::reg_idx_t'(cfg_idx))
        ttr_pkg::REG_DOWNSCALE: steps_r <= cfg_wdata[3:0];
        ttr_pkg::REG_MIN_SIDE:  min_r   <= cfg_wdata[ttr_pkg::SIDE_W-1:0];
        ttr_pkg::REG_MAX_SIDE:  max_r   <= cfg_wdata[ttr_pkg::SIDE_W-1:0];
        ttr_pkg::REG_VOLUME:    vol_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Entry cell
  logic                         f_v, f_rdy;
  logic [2*ttr_pkg::SIDE_W-1:0] f_prod;
  ttr_pkg::side_t               f_dvs;
  ttr_pkg::ctx1_t               f_ctx;

  ttr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .steps     (steps_r),
    .min_side  (min_r),
    .max_side  (max_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .ow        (in_ch.orig_width),
    .oh        (in_ch.orig_height),
    .align     (in_ch.align_needed),
    .bw        (in_ch.block_w),
    .bh        (in_ch.block_h),
    .out_valid (f_v),
    .out_ready (f_rdy),
    .out_prod  (f_prod),
    .out_dvs   (f_dvs),
    .out_ctx   (f_ctx)
  );

  // Aspect division: shorter side from the longer clamped side
  logic            a_v, a_rdy;
  ttr_pkg::side_t  a_quo, a_rem;
  logic [CW1-1:0]  a_ctxv;
  ttr_pkg::ctx1_t  a_ctx;

  ttr_div_chain #(.CW(CW1)) u_aspect (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_v),
    .in_ready  (f_rdy),
    .in_rem    (f_prod[2*ttr_pkg::SIDE_W-1:ttr_pkg::SIDE_W]),
    .in_nlo    (f_prod[ttr_pkg::SIDE_W-1:0]),
    .in_dvs    (f_dvs),
    .in_ctx    (f_ctx),
    .out_valid (a_v),
    .out_ready (a_rdy),
    .out_quo   (a_quo),
    .out_rem   (a_rem),
    .out_ctx   (a_ctxv)
  );
  assign a_ctx = ttr_pkg::ctx1_t'(a_ctxv);

  // Pick the recomputed side and set up the scale division
  ttr_pkg::side_t  tw1, th1;
  ttr_pkg::ctx2_t  s_in_ctx;
  assign tw1 = a_ctx.lt  ? a_quo : a_ctx.tw0;
  assign th1 = a_ctx.wgt ? a_quo : a_ctx.th0;
  assign s_in_ctx = '{ow: a_ctx.ow, tw1: tw1, th1: th1, align: a_ctx.align,
                      bw: a_ctx.bw, bh: a_ctx.bh, hzero: (th1 == '0)};

  logic            s_v, s_rdy;
  ttr_pkg::side_t  s_quo, s_rem;
  logic [CW2-1:0]  s_ctxv;
  ttr_pkg::ctx2_t  s_ctx;

  ttr_div_chain #(.CW(CW2)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_v),
    .in_ready  (a_rdy),
    .in_rem    ('0),
    .in_nlo    (a_ctx.oh),
    .in_dvs    ((th1 == '0) ? ttr_pkg::side_t'(1) : th1),
    .in_ctx    (s_in_ctx),
    .out_valid (s_v),
    .out_ready (s_rdy),
    .out_quo   (s_quo),
    .out_rem   (s_rem),
    .out_ctx   (s_ctxv)
  );
  assign s_ctx = ttr_pkg::ctx2_t'(s_ctxv);

  // Volume width division: orig_width / scale
  logic            szero;
  ttr_pkg::ctx3_t  w_in_ctx;
  assign szero = (s_quo == '0);
  assign w_in_ctx = '{tw1: s_ctx.tw1, th1: s_ctx.th1, align: s_ctx.align,
                      bw: s_ctx.bw, bh: s_ctx.bh, hzero: s_ctx.hzero, szero: szero};

  logic            w_v, w_rdy;
  ttr_pkg::side_t  w_quo, w_rem;
  logic [CW3-1:0]  w_ctxv;
  ttr_pkg::ctx3_t  w_ctx;

  ttr_div_chain #(.CW(CW3)) u_volw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_v),
    .in_ready  (s_rdy),
    .in_rem    ('0),
    .in_nlo    (s_ctx.ow),
    .in_dvs    (szero ? ttr_pkg::side_t'(1) : s_quo),
    .in_ctx    (w_in_ctx),
    .out_valid (w_v),
    .out_ready (w_rdy),
    .out_quo   (w_quo),
    .out_rem   (w_rem),
    .out_ctx   (w_ctxv)
  );
  assign w_ctx = ttr_pkg::ctx3_t'(w_ctxv);

  // Apply the volume rule, then set up the width block division
  logic            fault;
  ttr_pkg::side_t  tw2;
  ttr_pkg::blk_t   bwd, bhd;
  ttr_pkg::ctx4_t  bw_in_ctx;
  assign fault = vol_r && (w_ctx.hzero || w_ctx.szero);
  assign tw2   = vol_r ? (fault ? '0 : w_quo) : w_ctx.tw1;
  assign bwd   = (w_ctx.bw == '0) ? ttr_pkg::blk_t'(1) : w_ctx.bw;
  assign bhd   = (w_ctx.bh == '0) ? ttr_pkg::blk_t'(1) : w_ctx.bh;
  assign bw_in_ctx = '{th2: w_ctx.th1, tw2: tw2, bwd: bwd, bhd: bhd,
                       align: w_ctx.align, fault: fault};

  logic            bwc_v, bwc_rdy;
  ttr_pkg::side_t  bwc_quo, bwc_rem;
  logic [CW4-1:0]  bwc_ctxv;
  ttr_pkg::ctx4_t  bwc_ctx;

  ttr_div_chain #(.CW(CW4)) u_blkw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (w_v),
    .in_ready  (w_rdy),
    .in_rem    ('0),
    .in_nlo    (tw2),
    .in_dvs    (ttr_pkg::side_t'(bwd)),
    .in_ctx    (bw_in_ctx),
    .out_valid (bwc_v),
    .out_ready (bwc_rdy),
    .out_quo   (bwc_quo),
    .out_rem   (bwc_rem),
    .out_ctx   (bwc_ctxv)
  );
  assign bwc_ctx = ttr_pkg::ctx4_t'(bwc_ctxv);

  // Height block division
  ttr_pkg::ctx5_t  bh_in_ctx;
  assign bh_in_ctx = '{th2: bwc_ctx.th2, tw2: bwc_ctx.tw2, remw: bwc_rem,
                       bwd: bwc_ctx.bwd, bhd: bwc_ctx.bhd,
                       align: bwc_ctx.align, fault: bwc_ctx.fault};

  logic            bhc_v, bhc_rdy;
  ttr_pkg::side_t  bhc_quo, bhc_rem;
  logic [CW5-1:0]  bhc_ctxv;
  ttr_pkg::ctx5_t  bhc_ctx;

  ttr_div_chain #(.CW(CW5)) u_blkh (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bwc_v),
    .in_ready  (bwc_rdy),
    .in_rem    ('0),
    .in_nlo    (bwc_ctx.th2),
    .in_dvs    (ttr_pkg::side_t'(bwc_ctx.bhd)),
    .in_ctx    (bh_in_ctx),
    .out_valid (bhc_v),
    .out_ready (bhc_rdy),
    .out_quo   (bhc_quo),
    .out_rem   (bhc_rem),
    .out_ctx   (bhc_ctxv)
  );
  assign bhc_ctx = ttr_pkg::ctx5_t'(bhc_ctxv);

  // Remainders of the intermediate rows and quotients of the block rows are not needed downstream
  logic unused_q;
  assign unused_q = ^{a_rem, s_rem, w_rem, bwc_quo, bhc_quo};

  // Round up to block multiples with saturation
  logic [ttr_pkg::SIDE_W:0] sum_w, sum_h;
  ttr_pkg::side_t           tw_nxt, th_nxt;
  logic                     adj_w, adj_h;

  always_comb begin
    adj_w = bhc_ctx.align && (bhc_ctx.remw != '0);
    adj_h = bhc_ctx.align && (bhc_rem != '0);
    sum_w = {1'b0, bhc_ctx.tw2} + (ttr_pkg::SIDE_W+1)'(bhc_ctx.bwd)
            - {1'b0, bhc_ctx.remw};
    sum_h = {1'b0, bhc_ctx.th2} + (ttr_pkg::SIDE_W+1)'(bhc_ctx.bhd)
            - {1'b0, bhc_rem};
    tw_nxt = !adj_w ? bhc_ctx.tw2 :
             (sum_w[ttr_pkg::SIDE_W] ? '1 : sum_w[ttr_pkg::SIDE_W-1:0]);
    th_nxt = !adj_h ? bhc_ctx.th2 :
             (sum_h[ttr_pkg::SIDE_W] ? '1 : sum_h[ttr_pkg::SIDE_W-1:0]);
  end

  // Output register
  logic            out_valid_r;
  ttr_pkg::side_t  tw_r, th_r;
  logic            adj_r, fault_r;

  assign bhc_rdy = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (bhc_rdy) begin
      out_valid_r <= bhc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (bhc_rdy && bhc_v) begin
      tw_r    <= tw_nxt;
      th_r    <= th_nxt;
      adj_r   <= adj_w || adj_h;
      fault_r <= bhc_ctx.fault ^ (unused_q & 1'b0);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.target_width   = tw_r;
  assign out_ch.target_height  = th_r;
  assign out_ch.align_adjusted = adj_r;
  assign out_ch.divide_fault   = fault_r;

endmodule

FILE: sv/ttr_checker.sv
// ----------------------------------------------------------------------------
// ttr_checker
// Port-level checks of the texture target resolution unit.
// ----------------------------------------------------------------------------
module ttr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ttr_pkg::side_t target_width,
  input ttr_pkg::side_t target_height,
  input logic           divide_fault
);

  // Input backs up only when the result side is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without an output stall");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // A faulted volume width is zero, and block rounding keeps it zero
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && divide_fault) |-> (target_width == '0))
    else $error("divide fault with nonzero width");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(target_width)
                                   && $stable(target_height)))
    else $error("stalled result changed");

endmodule

bind texture_target_resolution_unit ttr_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .target_width  (out_ch.target_width),
  .target_height (out_ch.target_height),
  .divide_fault  (out_ch.divide_fault)
);

FILE: tb/tb_texture_target_resolution_unit.sv
// ----------------------------------------------------------------------------
// tb_texture_target_resolution_unit
// Checks the target resolution unit against a behavioral size predictor
// across several register settings, directed corner queries and random ones,
// with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_texture_target_resolution_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ttr_pkg::side_t tw;
    ttr_pkg::side_t th;
    logic           adj;
    logic           fault;
  } size_res_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
    errors++;
  endtask

  // Predicts target sizes and holds them until the block returns them
  class size_scoreboard;
    int unsigned steps = 0, min_s = 1, max_s = 16384, vol = 0;
    size_res_t pending[$];
    int checked = 0;

    function int unsigned clamp(int unsigned v);
      if (v < min_s) return min_s;
      if (v > max_s) return max_s;
      return v;
    endfunction

    function int unsigned round_blk(int unsigned v, int unsigned b, ref bit chg);
      int unsigned r;
      if (b == 0) b = 1;
      if (v % b == 0) return v;
      chg = 1;
      r = ((v + b - 1) / b) * b;
      return (r > 32767) ? 32767 : r;
    endfunction

    function void note_query(int unsigned ow, int unsigned oh, bit al,
                             int unsigned bw, int unsigned bh);
      int unsigned tw, th, sc;
      bit chg, flt;
      size_res_t r;
      chg = 0; flt = 0;
      tw = clamp(ow >> steps);
      th = clamp(oh >> steps);
      if (ow > oh) th = (tw * oh) / ow;
      else if (ow < oh) tw = (th * ow) / oh;
      if (vol) begin
        sc = (th != 0) ? oh / th : 0;
        if (sc == 0) begin
          flt = 1;
          tw = 0;
        end else begin
          tw = ow / sc;
        end
      end
      if (al) begin
        tw = round_blk(tw, bw, chg);
        th = round_blk(th, bh, chg);
      end
      r.tw = tw[14:0]; r.th = th[14:0]; r.adj = chg; r.fault = flt;
      pending.push_back(r);
    endfunction

    task check_result(size_res_t got);
      size_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result width", got.tw, -1);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.tw != e.tw) report_mismatch("target_width", got.tw, e.tw);
      if (got.th != e.th) report_mismatch("target_height", got.th, e.th);
      if (got.adj != e.adj) report_mismatch("align_adjusted", got.adj, e.adj);
      if (got.fault != e.fault) report_mismatch("divide_fault", got.fault, e.fault);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [ttr_pkg::IDX_W-1:0] cfg_idx = '0;
  logic [ttr_pkg::CFG_W-1:0] cfg_wdata = '0;
  ttr_in_if  in_ch();
  ttr_out_if out_ch();

  texture_target_resolution_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  size_scoreboard sb = new();
  int send_idle_pct = 19, recv_idle_pct = 73;
  int hold_cycles = 0;
  int n_sent = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    in_ch.valid = 0; in_ch.orig_width = 1; in_ch.orig_height = 1;
    in_ch.align_needed = 0; in_ch.block_w = 1; in_ch.block_h = 1;
    out_ch.ready = 0;
  end

  // Receiver: random stalls plus a counted hold-off; check at the rising edge
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.target_width, out_ch.target_height,
                       out_ch.align_adjusted, out_ch.divide_fault});
  end

  task automatic write_reg(input ttr_pkg::reg_idx_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val[ttr_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      ttr_pkg::REG_DOWNSCALE: sb.steps = val & 4'hF;
      ttr_pkg::REG_MIN_SIDE:  sb.min_s = val & 15'h7FFF;
      ttr_pkg::REG_MAX_SIDE:  sb.max_s = val & 15'h7FFF;
      default:                sb.vol = val & 1;
    endcase
  endtask

  // Offer one query, with a random gap first; return once it is accepted
  task automatic send_query(input int unsigned ow, input int unsigned oh, input bit al,
                            input int unsigned bw, input int unsigned bh);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.orig_width <= ow; in_ch.orig_height <= oh; in_ch.align_needed <= al;
    in_ch.block_w <= bw; in_ch.block_h <= bh;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_query(ow, oh, al, bw, bh);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic int unsigned rand_side();
    case ($urandom_range(3))
      0: return $urandom_range(1, 64);
      1: return $urandom_range(1, 16384);
      2: return 16384 - $urandom_range(0, 15);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  task automatic random_burst(input int n);
    repeat (n)
      send_query(rand_side(), rand_side(), $urandom_range(1),
                 $urandom_range(0, 31), $urandom_range(0, 31));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed corners under reset settings
    send_query(1, 1, 0, 1, 1);
    send_query(16384, 16384, 1, 16, 16);
    send_query(16384, 1, 1, 3, 5);
    send_query(1, 16384, 1, 7, 9);
    send_query(1000, 1000, 1, 0, 0);
    send_query(32767, 32767, 1, 31, 31);
    send_query(32767, 3, 1, 16, 16);
    send_query(333, 777, 1, 10, 6);
    drain();

    // Crossed clamp bounds, deepest downscale, volume with divide fault
    write_reg(ttr_pkg::REG_DOWNSCALE, 15);
    write_reg(ttr_pkg::REG_MIN_SIDE, 300);
    write_reg(ttr_pkg::REG_MAX_SIDE, 100);
    write_reg(ttr_pkg::REG_VOLUME, 1);
    send_query(16384, 16384, 1, 16, 3);
    send_query(5, 16384, 1, 7, 7);
    send_query(16384, 5, 0, 1, 1);
    drain();
    write_reg(ttr_pkg::REG_DOWNSCALE, 0);
    send_query(16384, 20, 1, 16, 16);
    send_query(200, 16384, 0, 1, 1);
    send_query(0, 0, 1, 5, 5);
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ttr_pkg::REG_DOWNSCALE, (ph == 5) ? 15 : $urandom_range(0, 6));
      write_reg(ttr_pkg::REG_MIN_SIDE, (ph == 0) ? 1 : $urandom_range(1, 512));
      write_reg(ttr_pkg::REG_MAX_SIDE, (ph == 1) ? 32767 : $urandom_range(256, 16384));
      write_reg(ttr_pkg::REG_VOLUME, ph % 2);
      if (ph == 2) begin
        send_idle_pct = 73; recv_idle_pct = 19;
      end else if (ph == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (ph == 4) hold_cycles = 300;
      random_burst(140);
      drain();
    end

    $display("covered %0d queries, %0d results checked, under reset and programmed settings",
             n_sent, sb.checked);
    $display("including clamp crossings, volume faults and a long output stall");
    if (errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
